/* rtl/lhsu_pkg.sv */
// Shared constants, types and saturation helper for the LLG Heun spin update unit.
package lhsu_pkg;

	localparam int ATOM_SLOTS     = 1024;
	localparam int MATERIAL_COUNT = 3;
	localparam int SPIN_BITS      = 32;
	localparam int SPIN_SAT_BITS  = (SPIN_BITS > 32) ? 32 : SPIN_BITS;
	localparam int SLOT_AW        = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
	localparam int SLOT_W         = 10;
	localparam int WORD_W         = 32;
	localparam int FIELD_SAT_BITS = 32;
	localparam int FRAC_SPIN      = 30;
	localparam int DT_TO_SPIN     = 22;

	localparam int ROOT_BITS   = 32;
	localparam int ROOT_STEPS  = 4;
	localparam int ROOT_STAGES = ROOT_BITS / ROOT_STEPS;
	localparam int DIV_BITS    = FRAC_SPIN + 1;
	localparam int DIV_STEPS   = 4;
	localparam int DIV_STAGES  = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_CORRECT = 1'b1;

	localparam logic [2:0] CFG_TIME_STEP      = 3'd0;
	localparam logic [2:0] CFG_HALF_TIME_STEP = 3'd1;
	localparam logic [2:0] CFG_PRECESS_M0     = 3'd2;
	localparam logic [2:0] CFG_DAMP_M0        = 3'd3;
	localparam logic [2:0] CFG_PRECESS_M1     = 3'd4;
	localparam logic [2:0] CFG_DAMP_M1        = 3'd5;
	localparam logic [2:0] CFG_PRECESS_M2     = 3'd6;
	localparam logic [2:0] CFG_DAMP_M2        = 3'd7;

	// cyclic neighbors of a vector component for the cross product
	localparam int NEXT1 [3] = '{1, 2, 0};
	localparam int NEXT2 [3] = '{2, 0, 1};

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} tag_t;

	function automatic word_t sat_word(input logic signed [71:0] v, input int bits);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		hi = (72'sd1 <<< (bits - 1)) - 72'sd1;
		lo = -hi - 72'sd1;
		if (v > hi)
			return hi[WORD_W-1:0];
		else if (v < lo)
			return lo[WORD_W-1:0];
		else
			return v[WORD_W-1:0];
	endfunction

endpackage

/* rtl/lhsu_normalize.sv */
// Pipelined vector normalizer: squared length, integer square root, three dividers.
module lhsu_normalize (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  lhsu_pkg::tag_t  in_tag,
	input  lhsu_pkg::word_t in_vec [3],
	output lhsu_pkg::tag_t  out_tag,
	output lhsu_pkg::word_t out_vec [3]
);
	import lhsu_pkg::*;

	typedef struct packed {
		logic [63:0]          rad;
		logic [35:0]          rem;
		logic [ROOT_BITS-1:0] root;
	} root_st_t;

	typedef struct packed {
		logic [32:0]         r;
		logic [DIV_BITS-1:0] q;
	} div_st_t;

	function automatic root_st_t root_step(input root_st_t st);
		root_st_t   o;
		logic [35:0] trial;
		o = st;
		for (int j = 0; j < ROOT_STEPS; j++) begin
			o.rem = {o.rem[33:0], o.rad[63:62]};
			o.rad = {o.rad[61:0], 2'b00};
			trial = {2'b00, o.root, 2'b01};
			if (o.rem >= trial) begin
				o.rem  = o.rem - trial;
				o.root = {o.root[ROOT_BITS-2:0], 1'b1};
			end else begin
				o.root = {o.root[ROOT_BITS-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	function automatic div_st_t div_step(input div_st_t st, input logic [31:0] n,
			input int steps);
		div_st_t     o;
		logic        t;
		logic [32:0] r2;
		o = st;
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (j < steps) begin
				t  = (o.r >= {1'b0, n});
				r2 = t ? (o.r - {1'b0, n}) : o.r;
				o.r = {r2[31:0], 1'b0};
				o.q = {o.q[DIV_BITS-2:0], t};
			end
		end
		return o;
	endfunction

	// magnitude and squares
	tag_t        tag_n1;
	logic [31:0] mag_n1 [3];
	logic        neg_n1 [3];
	logic [63:0] sq_n1 [3];
	logic [31:0] mag_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = in_vec[i][WORD_W-1] ? 32'(-in_vec[i]) : 32'(in_vec[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_n1 <= '0;
		else if (adv)
			tag_n1 <= in_tag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mag_n1[i] <= mag_c[i];
				neg_n1[i] <= in_vec[i][WORD_W-1];
				sq_n1[i]  <= mag_c[i] * mag_c[i];
			end
		end
	end

	// square root pipeline, index 0 loaded with the squared length
	tag_t        tag_r  [ROOT_STAGES+1];
	root_st_t    root_r [ROOT_STAGES+1];
	logic [31:0] mag_r  [ROOT_STAGES+1][3];
	logic        neg_r  [ROOT_STAGES+1][3];
	logic        zero_r [ROOT_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_r[0] <= '0;
		else if (adv)
			tag_r[0] <= tag_n1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_r[0].rad  <= sq_n1[0] + sq_n1[1] + sq_n1[2];
			root_r[0].rem  <= '0;
			root_r[0].root <= '0;
			zero_r[0]      <= (mag_n1[0] == 32'd0) && (mag_n1[1] == 32'd0)
				&& (mag_n1[2] == 32'd0);
			for (int i = 0; i < 3; i++) begin
				mag_r[0][i] <= mag_n1[i];
				neg_r[0][i] <= neg_n1[i];
			end
		end
	end

	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tag_r[k+1] <= '0;
			else if (adv)
				tag_r[k+1] <= tag_r[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_r[k+1] <= root_step(root_r[k]);
				zero_r[k+1] <= zero_r[k];
				for (int i = 0; i < 3; i++) begin
					mag_r[k+1][i] <= mag_r[k][i];
					neg_r[k+1][i] <= neg_r[k][i];
				end
			end
		end
	end

	// dividers: quotient of mag * 2^30 by the root, one bit a step
	tag_t        tag_d  [DIV_STAGES+1];
	div_st_t     div_d  [DIV_STAGES+1][3];
	logic [31:0] norm_d [DIV_STAGES+1];
	logic        neg_d  [DIV_STAGES+1][3];
	logic        zero_d [DIV_STAGES+1];

	always_comb begin
		tag_d[0]  = tag_r[ROOT_STAGES];
		norm_d[0] = root_r[ROOT_STAGES].root;
		zero_d[0] = zero_r[ROOT_STAGES];
		for (int i = 0; i < 3; i++) begin
			div_d[0][i].r = {1'b0, mag_r[ROOT_STAGES][i]};
			div_d[0][i].q = '0;
			neg_d[0][i]   = neg_r[ROOT_STAGES][i];
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int STEPS = ((DIV_BITS - k * DIV_STEPS) < DIV_STEPS) ?
			(DIV_BITS - k * DIV_STEPS) : DIV_STEPS;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tag_d[k+1] <= '0;
			else if (adv)
				tag_d[k+1] <= tag_d[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				norm_d[k+1] <= norm_d[k];
				zero_d[k+1] <= zero_d[k];
				for (int i = 0; i < 3; i++) begin
					div_d[k+1][i] <= div_step(div_d[k][i], norm_d[k], STEPS);
					neg_d[k+1][i] <= neg_d[k][i];
				end
			end
		end
	end

	// apply sign, force the zero vector
	word_t mag_q_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_q_c[i] = word_t'({{(WORD_W-DIV_BITS){1'b0}}, div_d[DIV_STAGES][i].q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_tag <= '0;
		else if (adv)
			out_tag <= tag_d[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_d[DIV_STAGES])
					out_vec[i] <= '0;
				else if (neg_d[DIV_STAGES][i])
					out_vec[i] <= -mag_q_c[i];
				else
					out_vec[i] <= mag_q_c[i];
			end
		end
	end

endmodule

/* rtl/llg_heun_spin_update_unit.sv */
// Top level of the LLG Heun spin update unit: derivative pipeline, atom store, step and normalize.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | in        | in_valid / in_stall  | opcode, atom_slot, material_sel, spin, fields
//  out      | out       | out_valid / out_stall| out_slot, new_spin_x/y/z
//  cfg      | in        | cfg_wr_en            | cfg_index, cfg_data
//
// One request enters every cycle while the output is not stalled.
// The pipeline depth is set by the chain of cross products, the multiply stages, the 32-step
// square root (four steps a stage) and the 31-step dividers (four steps a stage).
// The whole pipeline advances together: a stalled output freezes every stage and
// asserts in_stall, so nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers; the atom store has
// no reset and a correct request must follow the predict request for its slot.
module llg_heun_spin_update_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [lhsu_pkg::SLOT_W-1:0] atom_slot,
	input  logic [1:0]                material_sel,
	input  logic signed [31:0]        spin_x,
	input  logic signed [31:0]        spin_y,
	input  logic signed [31:0]        spin_z,
	input  logic signed [31:0]        exch_field_x,
	input  logic signed [31:0]        exch_field_y,
	input  logic signed [31:0]        exch_field_z,
	input  logic signed [31:0]        ext_field_x,
	input  logic signed [31:0]        ext_field_y,
	input  logic signed [31:0]        ext_field_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lhsu_pkg::SLOT_W-1:0] out_slot,
	output logic signed [31:0]        new_spin_x,
	output logic signed [31:0]        new_spin_y,
	output logic signed [31:0]        new_spin_z
);
	import lhsu_pkg::*;

	typedef struct packed {
		logic [2:0][WORD_W-1:0] spin;
		logic [2:0][WORD_W-1:0] deriv;
	} atom_rec_t;

	// configuration registers
	logic [31:0] time_step_q;
	logic [31:0] half_time_step_q;
	logic [30:0] precess_q [3];
	logic [30:0] damp_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q      <= '0;
			half_time_step_q <= '0;
			for (int m = 0; m < 3; m++) begin
				precess_q[m] <= '0;
				damp_q[m]    <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TIME_STEP:      time_step_q      <= cfg_data;
				CFG_HALF_TIME_STEP: half_time_step_q <= cfg_data;
				CFG_PRECESS_M0:     precess_q[0]     <= cfg_data[30:0];
				CFG_DAMP_M0:        damp_q[0]        <= cfg_data[30:0];
				CFG_PRECESS_M1:     precess_q[1]     <= cfg_data[30:0];
				CFG_DAMP_M1:        damp_q[1]        <= cfg_data[30:0];
				CFG_PRECESS_M2:     precess_q[2]     <= cfg_data[30:0];
				CFG_DAMP_M2:        damp_q[2]        <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// global advance: hold every stage while the output register is full and stalled
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// input side: total field and material coefficients
	word_t      spin_c [3];
	word_t      exch_c [3];
	word_t      ext_c  [3];
	logic [1:0] mat_c;

	assign spin_c = '{spin_x, spin_y, spin_z};
	assign exch_c = '{exch_field_x, exch_field_y, exch_field_z};
	assign ext_c  = '{ext_field_x, ext_field_y, ext_field_z};
	assign mat_c  = (32'(material_sel) >= MATERIAL_COUNT) ? 2'(MATERIAL_COUNT - 1) :
		material_sel;

	// stage 1: registered request with total field
	logic              vld_s1;
	logic              op_s1;
	logic [SLOT_W-1:0] slot_s1;
	word_t             spin_s1 [3];
	word_t             fld_s1 [3];
	logic [30:0]       prc_s1;
	logic [30:0]       dmp_s1;

	// stage 2: products of spin x field
	logic                vld_s2;
	logic                op_s2;
	logic [SLOT_W-1:0]   slot_s2;
	word_t               spin_s2 [3];
	logic [30:0]         prc_s2;
	logic [30:0]         dmp_s2;
	logic signed [63:0]  pa_s2 [3];
	logic signed [63:0]  pb_s2 [3];

	// stage 3: first cross product
	logic              vld_s3;
	logic              op_s3;
	logic [SLOT_W-1:0] slot_s3;
	word_t             spin_s3 [3];
	logic [30:0]       prc_s3;
	logic [30:0]       dmp_s3;
	word_t             crs_s3 [3];

	// stage 4: products of spin x cross
	logic               vld_s4;
	logic               op_s4;
	logic [SLOT_W-1:0]  slot_s4;
	word_t              spin_s4 [3];
	logic [30:0]        prc_s4;
	logic [30:0]        dmp_s4;
	word_t              crs_s4 [3];
	logic signed [63:0] pa_s4 [3];
	logic signed [63:0] pb_s4 [3];

	// stage 5: double cross product
	logic              vld_s5;
	logic              op_s5;
	logic [SLOT_W-1:0] slot_s5;
	word_t             spin_s5 [3];
	logic [30:0]       prc_s5;
	logic [30:0]       dmp_s5;
	word_t             crs_s5 [3];
	word_t             dcr_s5 [3];

	// stage 6: coefficient products
	logic               vld_s6;
	logic               op_s6;
	logic [SLOT_W-1:0]  slot_s6;
	word_t              spin_s6 [3];
	logic signed [63:0] pp_s6 [3];
	logic signed [63:0] dp_s6 [3];

	// stage 7: derivative, atom store access
	logic              vld_s7;
	logic              op_s7;
	logic [SLOT_W-1:0] slot_s7;
	word_t             spin_s7 [3];
	word_t             der_s7 [3];

	// stage 8: stored start spin and Euler derivative
	logic              vld_s8;
	logic              op_s8;
	logic [SLOT_W-1:0] slot_s8;
	word_t             spin_s8 [3];
	word_t             der_s8 [3];
	atom_rec_t         rec_s8;

	// stage 9: step product
	logic               vld_s9;
	logic [SLOT_W-1:0]  slot_s9;
	word_t              base_s9 [3];
	logic signed [64:0] stp_s9 [3];

	// stage 10: unnormalized spin
	logic              vld_s10;
	logic [SLOT_W-1:0] slot_s10;
	word_t             raw_s10 [3];

	atom_rec_t         atom_mem_q [ATOM_SLOTS];
	logic [SLOT_AW-1:0] addr_s7;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// derivative pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= opcode;
			slot_s1 <= atom_slot;
			prc_s1  <= precess_q[mat_c];
			dmp_s1  <= damp_q[mat_c];
			for (int i = 0; i < 3; i++) begin
				spin_s1[i] <= spin_c[i];
				fld_s1[i]  <= sat_word(72'(exch_c[i]) + 72'(ext_c[i]), FIELD_SAT_BITS);
			end

			op_s2   <= op_s1;
			slot_s2 <= slot_s1;
			prc_s2  <= prc_s1;
			dmp_s2  <= dmp_s1;
			for (int i = 0; i < 3; i++) begin
				spin_s2[i] <= spin_s1[i];
				pa_s2[i]   <= spin_s1[NEXT1[i]] * fld_s1[NEXT2[i]];
				pb_s2[i]   <= spin_s1[NEXT2[i]] * fld_s1[NEXT1[i]];
			end

			op_s3   <= op_s2;
			slot_s3 <= slot_s2;
			prc_s3  <= prc_s2;
			dmp_s3  <= dmp_s2;
			for (int i = 0; i < 3; i++) begin
				spin_s3[i] <= spin_s2[i];
				crs_s3[i]  <= sat_word(72'((65'(pa_s2[i]) - 65'(pb_s2[i])) >>> FRAC_SPIN),
					FIELD_SAT_BITS);
			end

			op_s4   <= op_s3;
			slot_s4 <= slot_s3;
			prc_s4  <= prc_s3;
			dmp_s4  <= dmp_s3;
			for (int i = 0; i < 3; i++) begin
				spin_s4[i] <= spin_s3[i];
				crs_s4[i]  <= crs_s3[i];
				pa_s4[i]   <= spin_s3[NEXT1[i]] * crs_s3[NEXT2[i]];
				pb_s4[i]   <= spin_s3[NEXT2[i]] * crs_s3[NEXT1[i]];
			end

			op_s5   <= op_s4;
			slot_s5 <= slot_s4;
			prc_s5  <= prc_s4;
			dmp_s5  <= dmp_s4;
			for (int i = 0; i < 3; i++) begin
				spin_s5[i] <= spin_s4[i];
				crs_s5[i]  <= crs_s4[i];
				dcr_s5[i]  <= sat_word(72'((65'(pa_s4[i]) - 65'(pb_s4[i])) >>> FRAC_SPIN),
					FIELD_SAT_BITS);
			end

			op_s6   <= op_s5;
			slot_s6 <= slot_s5;
			for (int i = 0; i < 3; i++) begin
				spin_s6[i] <= spin_s5[i];
				pp_s6[i]   <= $signed({1'b0, prc_s5}) * crs_s5[i];
				dp_s6[i]   <= $signed({1'b0, dmp_s5}) * dcr_s5[i];
			end

			op_s7   <= op_s6;
			slot_s7 <= slot_s6;
			for (int i = 0; i < 3; i++) begin
				spin_s7[i] <= spin_s6[i];
				der_s7[i]  <= sat_word(72'((65'(pp_s6[i]) + 65'(dp_s6[i])) >>> FRAC_SPIN),
					FIELD_SAT_BITS);
			end
		end
	end

	// atom store: a predict writes and a correct reads in the same stage, so a correct
	// right behind its predict already sees the new entry
	assign addr_s7 = SLOT_AW'(32'(slot_s7) % ATOM_SLOTS);

	always_ff @(posedge clk) begin
		if (adv && vld_s7 && (op_s7 == OP_PREDICT)) begin
			for (int i = 0; i < 3; i++) begin
				atom_mem_q[addr_s7].spin[i]  <= spin_s7[i];
				atom_mem_q[addr_s7].deriv[i] <= der_s7[i];
			end
		end
		if (adv)
			rec_s8 <= atom_mem_q[addr_s7];
	end

	// step: predict uses dt * dS, correct uses half_dt * (dS0 + dSp)
	word_t       opnd_c [3];
	logic [31:0] fac_c;

	always_comb begin
		fac_c = (op_s8 == OP_PREDICT) ? time_step_q : half_time_step_q;
		for (int i = 0; i < 3; i++) begin
			if (op_s8 == OP_PREDICT)
				opnd_c[i] = der_s8[i];
			else
				opnd_c[i] = sat_word(72'(der_s8[i]) + 72'(word_t'(rec_s8.deriv[i])),
					FIELD_SAT_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s8   <= op_s7;
			slot_s8 <= slot_s7;
			for (int i = 0; i < 3; i++) begin
				spin_s8[i] <= spin_s7[i];
				der_s8[i]  <= der_s7[i];
			end

			slot_s9 <= slot_s8;
			for (int i = 0; i < 3; i++) begin
				stp_s9[i]  <= opnd_c[i] * $signed({1'b0, fac_c});
				base_s9[i] <= (op_s8 == OP_PREDICT) ? spin_s8[i] : word_t'(rec_s8.spin[i]);
			end

			slot_s10 <= slot_s9;
			for (int i = 0; i < 3; i++)
				raw_s10[i] <= sat_word(72'(base_s9[i]) + 72'(stp_s9[i] >>> DT_TO_SPIN),
					SPIN_SAT_BITS);
		end
	end

	// normalize and drive the output register
	tag_t  norm_in_tag;
	tag_t  norm_out_tag;
	word_t norm_out_vec [3];

	assign norm_in_tag = '{valid: vld_s10, slot: slot_s10};

	lhsu_normalize u_normalize (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_tag  (norm_in_tag),
		.in_vec  (raw_s10),
		.out_tag (norm_out_tag),
		.out_vec (norm_out_vec)
	);

	assign out_valid  = norm_out_tag.valid;
	assign out_slot   = norm_out_tag.slot;
	assign new_spin_x = norm_out_vec[0];
	assign new_spin_y = norm_out_vec[1];
	assign new_spin_z = norm_out_vec[2];

`ifndef ASSERT_OFF
	// a normalized component never exceeds one in Q1.30
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_spin_x <= 32'sd1073741824) && (new_spin_x >= -32'sd1073741824)
			&& (new_spin_y <= 32'sd1073741824) && (new_spin_y >= -32'sd1073741824)
			&& (new_spin_z <= 32'sd1073741824) && (new_spin_z >= -32'sd1073741824))
		else $error("normalized spin component out of range");

	// a request held by a stall keeps its place and slot
	a_hold_s7: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && !adv) |=> (vld_s7 && $stable(slot_s7) && $stable(op_s7)))
		else $error("stage 7 request changed while stalled");

	// a request taken at the input shows up in stage 1 on the next edge
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (vld_s1 && (slot_s1 == $past(atom_slot))))
		else $error("accepted request missing from stage 1");
`endif

endmodule
